// File: hw/rtl/life_grid_generation_step_unit_macros.svh
// Assertion macros shared by the grid step unit RTL
`ifndef LIFE_GRID_GENERATION_STEP_UNIT_MACROS_SVH
`define LIFE_GRID_GENERATION_STEP_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define LGS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LGS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/lgs_pkg.sv
// Shared types and constants for the grid step unit
package lgs_pkg;

  localparam int MAX_ROWS_DEF = 32;
  localparam int MAX_COLS_DEF = 32;

  localparam int CMD_W      = 2;
  localparam int COORD_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_DATA_W-1:0] CFG_RESET = 6'd32;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_IN_USE = 2'd0,
    REG_COLS_IN_USE = 2'd1
  } cfg_reg_t;

  // masked view a cell hands to its neighbours
  typedef struct packed {
    logic above;
    logic cur;
    logic below;
  } nbr_t;

  // common control to every cell in the chain
  typedef struct packed {
    logic rotate;
    logic gen;
    logic clear;
    logic wr_en;
    logic wr_val;
    logic first_row;
    logic row_active;
    logic below_active;
  } ctrl_t;

endpackage

// File: hw/rtl/lgs_if.sv
// Handshake channels: command in, result out, register write
interface lgs_cmd_if;
  import lgs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     command;
  logic [COORD_W-1:0]   cell_row;
  logic [COORD_W-1:0]   cell_col;
  logic                 write_alive;
  modport source (output valid, command, cell_row, cell_col, write_alive, input ready);
  modport sink   (input valid, command, cell_row, cell_col, write_alive, output ready);
endinterface

interface lgs_res_if;
  logic valid;
  logic ready;
  logic cell_alive;
  modport source (output valid, cell_alive, input ready);
  modport sink   (input valid, cell_alive, output ready);
endinterface

interface lgs_cfg_if;
  import lgs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/life_grid_generation_step_unit.sv
// Grid step unit top: command sequencer, chain of column cells, result register
// Read/write/clear: the row store rotates until the addressed row is at the head.
// Step: align the head to row 0, update every row in one full pass of the store, then the seek.
// A new command is taken only in idle, once the last result is registered; a result waits in the output register.
// Reset (synchronous, rst high): every cell dead, both registers 32, head at row 0.
module life_grid_generation_step_unit #(
  parameter int MAX_ROWS = lgs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = lgs_pkg::MAX_COLS_DEF
) (
  input logic       clk,
  input logic       rst,
  lgs_cmd_if.sink   cmd,
  lgs_res_if.source res,
  lgs_cfg_if.sink   cfg
);
  import lgs_pkg::*;
  `include "life_grid_generation_step_unit_macros.svh"

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int AW  = (RW > COORD_W) ? RW : COORD_W;
  localparam int RCW = ((RW > CFG_DATA_W) ? RW : CFG_DATA_W) + 1;
  localparam int CCW = ((CW > CFG_DATA_W) ? CW : CFG_DATA_W) + 1;
  localparam logic [RW-1:0] LAST_ROW = RW'(MAX_ROWS - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ALIGN = 4'b0010,
    ST_GEN   = 4'b0100,
    ST_SEEK  = 4'b1000
  } state_t;

  state_t               state, state_next;
  logic [RW-1:0]        head_row;
  logic [CFG_DATA_W-1:0] rows_in_use, cols_in_use;
  cmd_t                 cmd_q;
  logic [COORD_W-1:0]   row_q, col_q;
  logic                 wa_q;
  logic                 res_valid, res_alive;

  logic                 accept, resp_fire, tgt_act, seek_hit, head_zero, gen_last;
  ctrl_t                ctrl;
  nbr_t                 nbrs [MAX_COLS];
  logic [MAX_COLS-1:0]  heads, hits, col_act;
  logic                 sel_bit;

  assign cfg.ready = 1'b1;
  assign cmd.ready = (state == ST_IDLE);
  assign accept    = cmd.valid & cmd.ready;
  assign res.valid = res_valid;
  assign res.cell_alive = res_alive;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= CFG_RESET;
      cols_in_use <= CFG_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_ROWS_IN_USE: rows_in_use <= cfg.data;
        REG_COLS_IN_USE: cols_in_use <= cfg.data;
        default: ;
      endcase
    end
  end

  assign tgt_act = (RCW'(row_q) < RCW'(rows_in_use)) && (RCW'(row_q) < RCW'(MAX_ROWS))
                && (CCW'(col_q) < CCW'(cols_in_use)) && (CCW'(col_q) < CCW'(MAX_COLS));
  assign seek_hit  = (AW'(head_row) == AW'(row_q));
  assign head_zero = (head_row == '0);
  assign gen_last  = (state == ST_GEN) && (head_row == LAST_ROW);
  assign resp_fire = (state == ST_SEEK) && (!tgt_act || seek_hit) && (!res_valid || res.ready);

  always_comb begin
    ctrl.rotate = ((state == ST_SEEK) && tgt_act && !seek_hit)
               || ((state == ST_ALIGN) && !head_zero)
               || (state == ST_GEN);
    ctrl.gen          = (state == ST_GEN);
    ctrl.clear        = accept && (cmd_t'(cmd.command) == CMD_CLEAR);
    ctrl.wr_en        = resp_fire && (cmd_q == CMD_WRITE) && tgt_act;
    ctrl.wr_val       = wa_q;
    ctrl.first_row    = head_zero;
    ctrl.row_active   = (RCW'(head_row) < RCW'(rows_in_use));
    ctrl.below_active = (head_row != LAST_ROW)
                     && ((RCW'(head_row) + RCW'(1)) < RCW'(rows_in_use));
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = (cmd_t'(cmd.command) == CMD_STEP) ? ST_ALIGN : ST_SEEK;
      ST_ALIGN: if (head_zero) state_next = ST_GEN;
      ST_GEN:   if (gen_last) state_next = ST_SEEK;
      ST_SEEK:  if (resp_fire) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head_row  <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.rotate) head_row <= (head_row == LAST_ROW) ? '0 : head_row + RW'(1);
      if (resp_fire) res_valid <= 1'b1;
      else if (res.ready) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd_t'(cmd.command);
      row_q <= cmd.cell_row;
      col_q <= cmd.cell_col;
      wa_q  <= cmd.write_alive;
    end
    if (resp_fire) res_alive <= tgt_act & ((cmd_q == CMD_WRITE) ? wa_q : sel_bit);
  end

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
    nbr_t left, right;
    assign col_act[c] = (CCW'(c) < CCW'(cols_in_use));
    assign hits[c]    = (CCW'(col_q) == CCW'(c));
    if (c == 0) begin : g_l0
      assign left = '0;
    end else begin : g_l
      assign left = nbrs[c-1];
    end
    if (c == MAX_COLS - 1) begin : g_rn
      assign right = '0;
    end else begin : g_r
      assign right = nbrs[c+1];
    end
    lgs_cell #(.DEPTH(MAX_ROWS)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .col_active (col_act[c]),
      .hit        (hits[c]),
      .left       (left),
      .right      (right),
      .nbr        (nbrs[c]),
      .head_bit   (heads[c])
    );
  end

  assign sel_bit = |(heads & hits);

  `LGS_ASSERT_NEXT(a_busy_after_accept, accept, !cmd.ready, "ready held after accept")
  `LGS_ASSERT_NEXT(a_align_to_gen, (state == ST_ALIGN) && head_zero, state == ST_GEN, "align stuck")
  `LGS_ASSERT_NEXT(a_gen_wraps, gen_last, (state == ST_SEEK) && head_zero, "gen pass did not wrap")
  `LGS_ASSERT_NOW(a_wr_seek, ctrl.wr_en, (state == ST_SEEK) && seek_hit && !ctrl.rotate, "stray write")

endmodule

// File: hw/rtl/lgs_cell.sv
// One grid column: rotating row store and the B3/S23 update for its bit
module lgs_cell #(
  parameter int DEPTH = lgs_pkg::MAX_ROWS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  lgs_pkg::ctrl_t ctrl,
  input  logic          col_active,
  input  logic          hit,
  input  lgs_pkg::nbr_t left,
  input  lgs_pkg::nbr_t right,
  output lgs_pkg::nbr_t nbr,
  output logic          head_bit
);
  import lgs_pkg::*;

  logic [DEPTH-1:0] bits;
  logic             prev;
  logic [3:0]       n;
  logic             new_bit;

  assign head_bit  = bits[0];
  assign nbr.above = prev    & col_active & ~ctrl.first_row;
  assign nbr.cur   = bits[0] & col_active & ctrl.row_active;
  assign nbr.below = bits[1] & col_active & ctrl.below_active;

  always_comb begin
    n = 4'(left.above) + 4'(left.cur) + 4'(left.below)
      + 4'(right.above) + 4'(right.cur) + 4'(right.below)
      + 4'(nbr.above) + 4'(nbr.below);
    new_bit = col_active & ctrl.row_active & ((n == 4'd3) | (nbr.cur & (n == 4'd2)));
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      bits <= '0;
      prev <= 1'b0;
    end else if (ctrl.rotate) begin
      bits <= {(ctrl.gen ? new_bit : bits[0]), bits[DEPTH-1:1]};
      prev <= bits[0];
    end else if (ctrl.wr_en && hit) begin
      bits[0] <= ctrl.wr_val;
    end
  end

endmodule
